// ----- design/area_weighted_level_accumulator_macros.svh -----
// assertion macros used by the accumulator sequencer
`ifndef AREA_WEIGHTED_LEVEL_ACCUMULATOR_MACROS_SVH
`define AREA_WEIGHTED_LEVEL_ACCUMULATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define AWLA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define AWLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/awla_pkg.sv -----
// shared types and constants of the level accumulator
package awla_pkg;
    localparam int TICK_W  = 20;
    localparam int FRM_W   = 11;
    localparam int LVL_W   = 16;
    localparam int IDX_W   = 10;
    localparam int OUT_W   = 32;
    localparam int DIV_W   = 36;
    localparam int CFG_W   = 20;

    localparam logic CFG_TOTAL_TICKS   = 1'b0;
    localparam logic CFG_FRAMES_IN_USE = 1'b1;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [1:0] {
        CMD_ACK,
        CMD_ADD,
        CMD_READ
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                 kind;
        logic [TICK_W-1:0]         begin_tick;
        logic [TICK_W-1:0]         end_tick;
        logic signed [LVL_W-1:0]   lvl_l;
        logic signed [LVL_W-1:0]   lvl_r;
        logic [IDX_W-1:0]          frame_index;
        logic                      in_range;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL_CUR,
        ST_DIV_CUR,
        ST_MUL_FS,
        ST_DIV_FS,
        ST_MUL_NXT,
        ST_DIV_NXT,
        ST_MUL_LVL,
        ST_DIV_LVL,
        ST_NEXT,
        ST_RD_DATA,
        ST_ACK
    } t_back_state;
endpackage

// ----- design/awla_req_if.sv -----
// request channel of the level accumulator
interface awla_req_if;
    import awla_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [TICK_W-1:0]       start_tick;
    logic [TICK_W-1:0]       end_tick;
    logic signed [LVL_W-1:0] level_left;
    logic signed [LVL_W-1:0] level_right;
    logic [IDX_W-1:0]        frame_index;

    modport source (output valid, operation, start_tick, end_tick, level_left, level_right,
                    frame_index, input ready);
    modport sink (input valid, operation, start_tick, end_tick, level_left, level_right,
                  frame_index, output ready);
endinterface

// ----- design/awla_rsp_if.sv -----
// response channel of the level accumulator
interface awla_rsp_if;
    import awla_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    read_valid;
    logic signed [OUT_W-1:0] frame_left;
    logic signed [OUT_W-1:0] frame_right;

    modport source (output valid, read_valid, frame_left, frame_right, input ready);
    modport sink (input valid, read_valid, frame_left, frame_right, output ready);
endinterface

// ----- design/awla_front.sv -----
// request intake: tick masking, range check and command classification
module awla_front #(
    parameter int FRAME_DEPTH = 1024,
    parameter int TICK_BITS   = 20
) (
    awla_req_if.sink                     i_req,
    input  logic [awla_pkg::TICK_W-1:0]  i_total_ticks,
    input  logic [awla_pkg::FRM_W-1:0]   i_frames_in_use,
    input  logic                         i_full,
    input  logic                         i_clearing,
    output logic                         o_push,
    output awla_pkg::t_cmd               o_cmd
);
    import awla_pkg::*;

    localparam logic [TICK_W-1:0] TICK_MASK =
        (TICK_BITS >= TICK_W) ? {TICK_W{1'b1}} : TICK_W'((64'd1 << TICK_BITS) - 64'd1);

    logic [TICK_W-1:0] begin_m;
    logic [TICK_W-1:0] end_m;
    logic              skip;

    assign begin_m = i_req.start_tick & TICK_MASK;
    assign end_m   = i_req.end_tick & TICK_MASK;
    assign skip    = ((i_req.level_left == '0) && (i_req.level_right == '0))
                     || (i_total_ticks == '0) || (i_frames_in_use == '0)
                     || (end_m < begin_m);

    assign i_req.ready = !i_full && !i_clearing;
    assign o_push      = i_req.valid && i_req.ready;

    always_comb begin
        o_cmd.begin_tick  = begin_m;
        o_cmd.end_tick    = end_m;
        o_cmd.lvl_l       = i_req.level_left;
        o_cmd.lvl_r       = i_req.level_right;
        o_cmd.frame_index = i_req.frame_index;
        o_cmd.in_range    = (32'(i_req.frame_index) < FRAME_DEPTH);
        if (i_req.operation == OP_READ) begin
            o_cmd.kind = CMD_READ;
        end else if (skip) begin
            o_cmd.kind = CMD_ACK;
        end else begin
            o_cmd.kind = CMD_ADD;
        end
    end
endmodule

// ----- design/awla_fifo.sv -----
// two-entry command queue between intake and sequencer
module awla_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  awla_pkg::t_cmd   i_cmd,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output awla_pkg::t_cmd   o_cmd
);
    import awla_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

// ----- design/awla_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
module awla_div #(
    parameter int DW = 36,
    parameter int VW = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);
    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    assign trial  = {r_rem, r_q[DW-1]};
    assign diff   = trial - {1'b0, r_div};
    assign ge     = (trial >= {1'b0, r_div});
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
            r_q   <= {r_q[DW-2:0], ge};
        end
    end
endmodule

// ----- design/awla_back.sv -----
// sequencer: frame walk, divisions, sum memory read-modify-write and result register
`include "area_weighted_level_accumulator_macros.svh"
module awla_back #(
    parameter int FRAME_DEPTH = 1024,
    parameter int SUM_BITS    = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [awla_pkg::TICK_W-1:0]  i_total_ticks,
    input  logic [awla_pkg::FRM_W-1:0]   i_frames_in_use,
    input  logic                         i_cmd_valid,
    input  awla_pkg::t_cmd               i_cmd,
    output logic                         o_pop,
    output logic                         o_clearing,
    awla_rsp_if.source                   o_rsp
);
    import awla_pkg::*;

    localparam int AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int MW = 2 * SUM_BITS;

    t_back_state r_state, n_state;

    logic [MW-1:0] r_mem [FRAME_DEPTH];
    logic [MW-1:0] r_rd;
    logic          mem_re, mem_we;
    logic [AW-1:0] mem_raddr, mem_waddr;
    logic [MW-1:0] mem_wdata;

    logic [AW-1:0]            r_clr_addr;
    logic [TICK_W-1:0]        r_begin, r_end, r_fstart, r_nxt, r_flen;
    logic                     r_flen_nz;
    logic signed [LVL_W-1:0]  r_l, r_r;
    logic                     r_in_range;
    // index of the frame being read, held from the pop
    logic [IDX_W-1:0]         r_idx;
    logic [FRM_W-1:0]         r_cur;
    logic [DIV_W-1:0]         r_prod;
    logic [DIV_W-1:0]         r_mag_l, r_mag_r;
    logic                     r_neg_l, r_neg_r;
    logic                     r_div_go;
    logic                     r_out_valid, r_out_rd;
    logic signed [OUT_W-1:0]  r_out_l, r_out_r;

    logic                     slot_free;
    logic                     div_a_done, div_b_done;
    logic [DIV_W-1:0]         div_a_quot, div_b_quot;
    logic [DIV_W-1:0]         div_a_num;
    logic [TICK_W-1:0]        div_den;
    logic [TICK_W-1:0]        nxt_raw, nxt_clamp, flen;
    logic [FRM_W:0]           cur_inc;
    logic                     cur_fits;
    logic                     walk_done;
    logic [TICK_W-1:0]        seg_len;
    logic [LVL_W:0]           abs_l, abs_r;
    logic signed [63:0]       q_l, q_r;
    logic [SUM_BITS-1:0]      old_l, old_r, new_l, new_r;
    logic signed [SUM_BITS-1:0] rd_l, rd_r;

    assign slot_free  = !r_out_valid || o_rsp.ready;
    assign nxt_raw    = div_a_quot[TICK_W-1:0];
    assign flen       = nxt_raw - r_fstart;
    assign nxt_clamp  = (nxt_raw > r_end) ? r_end : nxt_raw;
    assign cur_inc    = {1'b0, r_cur} + 1'b1;
    assign cur_fits   = (32'(r_cur) < FRAME_DEPTH);
    assign walk_done  = (r_nxt >= r_end) || (cur_inc >= {1'b0, i_frames_in_use});
    assign seg_len    = r_nxt - r_begin;
    assign abs_l      = r_l[LVL_W-1] ? -{r_l[LVL_W-1], r_l} : {r_l[LVL_W-1], r_l};
    assign abs_r      = r_r[LVL_W-1] ? -{r_r[LVL_W-1], r_r} : {r_r[LVL_W-1], r_r};
    assign q_l        = r_neg_l ? -$signed(64'(div_a_quot)) : $signed(64'(div_a_quot));
    assign q_r        = r_neg_r ? -$signed(64'(div_b_quot)) : $signed(64'(div_b_quot));
    assign old_l      = r_rd[SUM_BITS-1:0];
    assign old_r      = r_rd[MW-1:SUM_BITS];
    assign new_l      = old_l + q_l[SUM_BITS-1:0];
    assign new_r      = old_r + q_r[SUM_BITS-1:0];
    assign rd_l       = $signed(old_l);
    assign rd_r       = $signed(old_r);
    assign o_clearing = (r_state == ST_CLEAR);

    // divider operand select, latched by the divider on its start
    always_comb begin
        div_a_num = r_prod;
        div_den   = TICK_W'(i_frames_in_use);
        case (r_state)
            ST_DIV_CUR: div_den = i_total_ticks;
            ST_DIV_LVL: begin
                div_a_num = r_mag_l;
                div_den   = r_flen;
            end
            default: ;
        endcase
    end

    awla_div #(.DW(DIV_W), .VW(TICK_W)) u_div_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (div_a_num),
        .i_divisor  (div_den),
        .o_done     (div_a_done),
        .o_quot     (div_a_quot)
    );

    awla_div #(.DW(DIV_W), .VW(TICK_W)) u_div_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go && (r_state == ST_DIV_LVL)),
        .i_dividend (r_mag_r),
        .i_divisor  (div_den),
        .o_done     (div_b_done),
        .o_quot     (div_b_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:   if (r_clr_addr == AW'(FRAME_DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        CMD_ADD:  n_state = ST_MUL_CUR;
                        CMD_READ: n_state = ST_RD_DATA;
                        default:  n_state = ST_ACK;
                    endcase
                end
            end
            ST_MUL_CUR: n_state = ST_DIV_CUR;
            ST_DIV_CUR: begin
                if (div_a_done) begin
                    n_state = (div_a_quot >= DIV_W'(i_frames_in_use)) ? ST_ACK : ST_MUL_FS;
                end
            end
            ST_MUL_FS:  n_state = ST_DIV_FS;
            ST_DIV_FS:  if (div_a_done) n_state = ST_MUL_NXT;
            ST_MUL_NXT: n_state = ST_DIV_NXT;
            ST_DIV_NXT: begin
                if (div_a_done) begin
                    n_state = ((flen != '0) && cur_fits) ? ST_MUL_LVL : ST_NEXT;
                end
            end
            ST_MUL_LVL: n_state = ST_DIV_LVL;
            ST_DIV_LVL: if (div_a_done) n_state = ST_NEXT;
            ST_NEXT:    n_state = walk_done ? ST_ACK : ST_MUL_NXT;
            ST_RD_DATA: if (slot_free) n_state = ST_IDLE;
            ST_ACK:     if (slot_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = AW'(r_cur);
        mem_we    = 1'b0;
        mem_waddr = AW'(r_cur);
        mem_wdata = {new_r, new_l};
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                o_pop     = i_cmd_valid;
                mem_re    = i_cmd_valid && (i_cmd.kind == CMD_READ) && i_cmd.in_range;
                mem_raddr = AW'(i_cmd.frame_index);
            end
            ST_MUL_LVL: mem_re = 1'b1;
            ST_DIV_LVL: mem_we = div_a_done;
            ST_RD_DATA: begin
                mem_we    = slot_free && r_in_range;
                mem_waddr = AW'(r_idx);
                mem_wdata = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= (r_state == ST_MUL_CUR) || (r_state == ST_MUL_FS)
                        || (r_state == ST_MUL_NXT) || (r_state == ST_MUL_LVL);
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (((r_state == ST_ACK) || (r_state == ST_RD_DATA)) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    r_begin    <= i_cmd.begin_tick;
                    r_end      <= i_cmd.end_tick;
                    r_l        <= i_cmd.lvl_l;
                    r_r        <= i_cmd.lvl_r;
                    r_in_range <= i_cmd.in_range;
                    r_idx      <= i_cmd.frame_index;
                end
            end
            ST_MUL_CUR: r_prod <= DIV_W'(32'(r_begin) * 32'(i_frames_in_use));
            ST_DIV_CUR: if (div_a_done) r_cur <= div_a_quot[FRM_W-1:0];
            ST_MUL_FS:  r_prod <= DIV_W'(32'(r_cur) * 32'(i_total_ticks));
            ST_DIV_FS:  if (div_a_done) r_fstart <= nxt_raw;
            ST_MUL_NXT: r_prod <= DIV_W'(32'(cur_inc) * 32'(i_total_ticks));
            ST_DIV_NXT: begin
                if (div_a_done) begin
                    r_fstart  <= nxt_raw;
                    r_nxt     <= nxt_clamp;
                    r_flen    <= flen;
                    r_flen_nz <= (flen != '0);
                end
            end
            ST_MUL_LVL: begin
                r_mag_l <= DIV_W'(abs_l * seg_len);
                r_mag_r <= DIV_W'(abs_r * seg_len);
                r_neg_l <= r_l[LVL_W-1];
                r_neg_r <= r_r[LVL_W-1];
            end
            ST_NEXT: begin
                if (r_flen_nz) begin
                    r_begin <= r_nxt;
                end
                r_cur <= cur_inc[FRM_W-1:0];
            end
            ST_RD_DATA: begin
                if (slot_free) begin
                    r_out_rd <= 1'b1;
                    r_out_l  <= r_in_range ? OUT_W'(rd_l) : '0;
                    r_out_r  <= r_in_range ? OUT_W'(rd_r) : '0;
                end
            end
            ST_ACK: begin
                if (slot_free) begin
                    r_out_rd <= 1'b0;
                    r_out_l  <= '0;
                    r_out_r  <= '0;
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_valid  = r_out_rd;
    assign o_rsp.frame_left  = r_out_l;
    assign o_rsp.frame_right = r_out_r;

    `AWLA_ASSERT_NOW(a_no_pop_in_clear, r_state == ST_CLEAR, !o_pop, "queue popped during clear")
    `AWLA_ASSERT_NOW(a_lanes_in_step, div_b_done, div_a_done, "divider lanes out of step")
    `AWLA_ASSERT_NOW(a_sum_write_in_range, (r_state == ST_DIV_LVL) && mem_we, cur_fits,
        "sum write beyond frame depth")
    `AWLA_ASSERT_NEXT(a_result_after_ack, (r_state == ST_ACK) && slot_free, r_out_valid,
        "acknowledge not presented")
endmodule

// ----- design/area_weighted_level_accumulator.sv -----
// top level of the area-weighted stereo level accumulator
// An add request spreads a stereo level held over [start_tick, end_tick) onto the output
// frames it overlaps: each frame gets level * covered ticks / frame ticks, truncated toward
// zero, added to its wrapping SUM_BITS sums. A read request returns one frame's sums and
// clears that frame. Every request gets exactly one response, in order. After reset the
// sum memory is swept to zero, one entry a cycle, with the request channel held not
// ready. An add first finds its first frame, then works through each covered frame; each
// step uses the 36-step divider, which retires one quotient bit a cycle, with two lanes
// for left and right. Requests that add nothing (both levels zero, empty period, reversed
// interval) are acknowledged without any division. A two-entry queue lets new requests
// land while the sequencer works, and the response register lets the sequencer go on
// while a response waits.
module area_weighted_level_accumulator #(
    parameter int FRAME_DEPTH = 1024,
    parameter int SUM_BITS    = 32,
    parameter int TICK_BITS   = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_index,
    input  logic [awla_pkg::CFG_W-1:0]  i_cfg_wdata,
    awla_req_if.sink                    i_req,
    awla_rsp_if.source                  o_rsp
);
    import awla_pkg::*;

    // configuration registers, to be written only while idle; the block does not enforce this
    logic [TICK_W-1:0] r_total_ticks;
    logic [FRM_W-1:0]  r_frames_in_use;

    // queue between intake and sequencer
    logic push, full, pop, cmd_valid, clearing;
    t_cmd front_cmd, back_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_ticks   <= TICK_W'(69888);
            r_frames_in_use <= FRM_W'(882);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_TOTAL_TICKS:   r_total_ticks   <= i_cfg_wdata[TICK_W-1:0];
                CFG_FRAMES_IN_USE: r_frames_in_use <= i_cfg_wdata[FRM_W-1:0];
                default: ;
            endcase
        end
    end

    // intake: classifies each request and masks its ticks
    awla_front #(.FRAME_DEPTH(FRAME_DEPTH), .TICK_BITS(TICK_BITS)) u_front (
        .i_req           (i_req),
        .i_total_ticks   (r_total_ticks),
        .i_frames_in_use (r_frames_in_use),
        .i_full          (full),
        .i_clearing      (clearing),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    awla_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (cmd_valid),
        .o_cmd   (back_cmd)
    );

    // sequencer: frame walk, divisions, memory update, response
    awla_back #(.FRAME_DEPTH(FRAME_DEPTH), .SUM_BITS(SUM_BITS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_total_ticks   (r_total_ticks),
        .i_frames_in_use (r_frames_in_use),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (back_cmd),
        .o_pop           (pop),
        .o_clearing      (clearing),
        .o_rsp           (o_rsp)
    );
endmodule

// ----- dv/area_weighted_level_accumulator_tb.sv -----
// self-checking testbench of the area-weighted stereo level accumulator
module area_weighted_level_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import awla_pkg::*;

    localparam int FRAME_DEPTH = 1024;
    localparam int SUM_BITS    = 32;
    localparam int RANDOM_REQS = 1750;
    localparam int STALL_LIMIT = 400000;
    localparam int DIR_ROWS    = 18;

    // one stimulus row, with an optional typed-in expectation
    typedef struct {
        logic                    op;
        logic [TICK_W-1:0]       start_t;
        logic [TICK_W-1:0]       end_t;
        logic signed [LVL_W-1:0] lvl_l;
        logic signed [LVL_W-1:0] lvl_r;
        logic [IDX_W-1:0]        idx;
        bit                      has_fixed;
        logic signed [OUT_W-1:0] fixed_l;
        logic signed [OUT_W-1:0] fixed_r;
    } t_row;

    typedef struct {
        logic                    read_valid;
        logic signed [OUT_W-1:0] left;
        logic signed [OUT_W-1:0] right;
    } t_frame_rsp;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_index;
    logic [CFG_W-1:0] i_cfg_wdata;

    awla_req_if req_bus();
    awla_rsp_if rsp_bus();

    area_weighted_level_accumulator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_bus.sink),
        .o_rsp       (rsp_bus.source)
    );

    // predictor state: frame sums kept at SUM_BITS, wrapping
    logic [SUM_BITS-1:0] sum_l [FRAME_DEPTH];
    logic [SUM_BITS-1:0] sum_r [FRAME_DEPTH];
    longint unsigned     period_ticks;
    longint unsigned     frame_count;

    t_frame_rsp pending_rsps[$];
    t_row       dir_rows[DIR_ROWS];

    int  mismatches;
    int  checked;
    int  reads_seen;
    int  idle_cycles;
    bit  quiet_mode;    // long stretch with no idling on either side
    int  sent_reqs;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // spread one level over [b, e) onto frames, truncating each share toward zero
    function automatic void spread_level(longint unsigned b, longint unsigned e,
                                         longint l, longint r);
        longint unsigned cur, nxt, flen, covered;
        longint          ql, qr;
        if (l == 0 && r == 0) return;
        if (period_ticks == 0 || frame_count == 0 || e < b) return;
        cur = b * frame_count / period_ticks;
        while (cur < frame_count) begin
            nxt  = (cur + 1) * period_ticks / frame_count;
            flen = nxt - cur * period_ticks / frame_count;
            if (nxt > e) nxt = e;
            if (flen != 0) begin
                covered = nxt - b;
                if (cur < FRAME_DEPTH) begin
                    ql = l * longint'(covered) / longint'(flen);
                    qr = r * longint'(covered) / longint'(flen);
                    sum_l[cur] = sum_l[cur] + ql[SUM_BITS-1:0];
                    sum_r[cur] = sum_r[cur] + qr[SUM_BITS-1:0];
                end
                b = nxt;
            end
            cur++;
            if (nxt >= e) break;
        end
    endfunction

    function automatic t_frame_rsp predict_frame_rsp(t_row rq);
        t_frame_rsp rsp;
        rsp = '{1'b0, '0, '0};
        if (rq.op == OP_ADD) begin
            spread_level(64'(rq.start_t), 64'(rq.end_t), longint'(rq.lvl_l),
                         longint'(rq.lvl_r));
        end else begin
            rsp.read_valid = 1'b1;
            rsp.left  = OUT_W'(signed'(sum_l[rq.idx]));
            rsp.right = OUT_W'(signed'(sum_r[rq.idx]));
            sum_l[rq.idx] = '0;
            sum_r[rq.idx] = '0;
        end
        if (rq.has_fixed) begin
            rsp.left  = rq.fixed_l;
            rsp.right = rq.fixed_r;
        end
        return rsp;
    endfunction

    function automatic bit roll_idle();
        return !quiet_mode && ($urandom_range(99) < 16);
    endfunction

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_TOTAL_TICKS) period_ticks = 64'(val);
        else frame_count = 64'(val[FRM_W-1:0]);
        @(posedge i_clk);
    endtask

    // drive one request and hold it until accepted; predictor runs at acceptance
    task automatic send_req(t_row rq);
        while (roll_idle()) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.operation   <= rq.op;
        req_bus.start_tick  <= rq.start_t;
        req_bus.end_tick    <= rq.end_t;
        req_bus.level_left  <= rq.lvl_l;
        req_bus.level_right <= rq.lvl_r;
        req_bus.frame_index <= rq.idx;
        do @(posedge i_clk); while (!(req_bus.valid && req_bus.ready));
        pending_rsps.push_back(predict_frame_rsp(rq));
        sent_reqs++;
    endtask

    // wait for all responses, then for the slowest add to drain
    task automatic drain();
        req_bus.valid <= 1'b0;
        while (pending_rsps.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic t_row make_row(logic op, int s, int e, int l, int r, int idx);
        t_row rq;
        rq.op = op;
        rq.start_t = TICK_W'(s);
        rq.end_t = TICK_W'(e);
        rq.lvl_l = LVL_W'(l);
        rq.lvl_r = LVL_W'(r);
        rq.idx = IDX_W'(idx);
        rq.has_fixed = 1'b0;
        rq.fixed_l = '0;
        rq.fixed_r = '0;
        return rq;
    endfunction

    // random request: mostly short in-period adds, reads mostly of frames in use
    function automatic t_row random_row();
        t_row rq;
        int   pick, s, e, span;
        pick = int'($urandom_range(99));
        rq = make_row(OP_ADD, 0, 0, int'($urandom), int'($urandom), int'($urandom));
        if (pick < 35) begin
            rq.op = OP_READ;
            if ($urandom_range(3) != 0 && frame_count > 0)
                rq.idx = IDX_W'((frame_count > FRAME_DEPTH)
                                ? $urandom_range(FRAME_DEPTH - 1)
                                : $urandom_range(32'(frame_count - 1)));
        end else if (pick < 88) begin
            // well-formed interval of a few frames at most
            s = (period_ticks > 0) ? int'($urandom_range(32'(period_ticks))) : 0;
            span = (frame_count > 0) ? int'(period_ticks / frame_count) * 3 + 2 : 3;
            e = s + int'($urandom_range(span));
            rq.start_t = TICK_W'(s);
            rq.end_t = (e > int'(period_ticks)) ? TICK_W'(period_ticks) : TICK_W'(e);
            if ($urandom_range(15) == 0) rq.lvl_l = '0;
            if ($urandom_range(15) == 0) rq.lvl_r = '0;
        end else if (pick < 94) begin
            // reversed interval or both levels zero: nothing added
            rq.start_t = TICK_W'($urandom);
            rq.end_t = TICK_W'($urandom);
            if ($urandom_range(1)) begin
                rq.lvl_l = '0;
                rq.lvl_r = '0;
            end else if (rq.end_t >= rq.start_t) begin
                if (rq.start_t == '0) rq.start_t = TICK_W'(1);
                rq.end_t = rq.start_t - TICK_W'(1);
            end
        end else begin
            // start near the end, interval beyond the period
            s = (period_ticks > 4) ? int'(period_ticks) - int'($urandom_range(4)) : 0;
            e = s + int'($urandom_range(1000));
            rq.start_t = TICK_W'(s);
            rq.end_t = (e > 1048575) ? TICK_W'(1048575) : TICK_W'(e);
        end
        return rq;
    endfunction

    // response side: random stalls, compare against the oldest expectation
    initial begin
        t_frame_rsp exp_rsp;
        rsp_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_bus.valid && rsp_bus.ready && i_rst_n) begin
                if (pending_rsps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response read_valid=%0b l=%0d r=%0d",
                                 rsp_bus.read_valid, rsp_bus.frame_left, rsp_bus.frame_right);
                end else begin
                    exp_rsp = pending_rsps.pop_front();
                    checked++;
                    if (exp_rsp.read_valid) reads_seen++;
                    if (rsp_bus.read_valid !== exp_rsp.read_valid
                        || rsp_bus.frame_left !== exp_rsp.left
                        || rsp_bus.frame_right !== exp_rsp.right) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("response %0d: expected rv=%0b l=%0d r=%0d, got rv=%0b l=%0d r=%0d",
                                     checked, exp_rsp.read_valid, exp_rsp.left, exp_rsp.right,
                                     rsp_bus.read_valid, rsp_bus.frame_left,
                                     rsp_bus.frame_right);
                    end
                end
            end
            rsp_bus.ready <= !roll_idle();
        end
    end

    // watchdog: cycles with no request or response moving
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int n;
        mismatches = 0;
        checked = 0;
        reads_seen = 0;
        sent_reqs = 0;
        quiet_mode = 1'b0;
        period_ticks = 69888;
        frame_count = 882;
        for (int k = 0; k < FRAME_DEPTH; k++) begin
            sum_l[k] = '0;
            sum_r[k] = '0;
        end
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_TOTAL_TICKS;
        i_cfg_wdata = '0;
        req_bus.valid = 1'b0;
        req_bus.operation = OP_ADD;
        req_bus.start_tick = '0;
        req_bus.end_tick = '0;
        req_bus.level_left = '0;
        req_bus.level_right = '0;
        req_bus.frame_index = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, run at reset settings
        dir_rows[0]  = make_row(OP_READ, 0, 0, 0, 0, 0);              // cleared after reset
        dir_rows[0].has_fixed = 1'b1;
        dir_rows[1]  = make_row(OP_READ, 0, 0, 0, 0, 1023);
        dir_rows[1].has_fixed = 1'b1;
        dir_rows[2]  = make_row(OP_ADD, 0, 79, 32767, -32768, 0);     // exactly frame 0
        dir_rows[3]  = make_row(OP_READ, 0, 0, 0, 0, 0);
        dir_rows[4]  = make_row(OP_ADD, 10, 300, -7, 5, 0);           // across frames
        dir_rows[5]  = make_row(OP_READ, 0, 0, 0, 0, 1);
        dir_rows[6]  = make_row(OP_READ, 0, 0, 0, 0, 2);
        dir_rows[7]  = make_row(OP_ADD, 5, 5, 0, 0, 0);               // both levels zero
        dir_rows[8]  = make_row(OP_ADD, 500, 100, 100, 100, 0);       // reversed interval
        dir_rows[9]  = make_row(OP_READ, 0, 0, 0, 0, 6);
        dir_rows[9].has_fixed = 1'b1;
        dir_rows[10] = make_row(OP_ADD, 69800, 1048575, 1, -1, 0);    // past the period
        dir_rows[11] = make_row(OP_READ, 0, 0, 0, 0, 881);
        dir_rows[12] = make_row(OP_ADD, 0, 0, 32767, 32767, 0);       // empty interval
        dir_rows[13] = make_row(OP_ADD, 1048575, 1048575, -32768, -32768, 1023);
        dir_rows[14] = make_row(OP_READ, 0, 0, 0, 0, 0);
        dir_rows[15] = make_row(OP_ADD, 79, 80, -32768, 32767, 0);
        dir_rows[16] = make_row(OP_READ, 0, 0, 0, 0, 1);
        dir_rows[17] = make_row(OP_READ, 0, 0, 0, 0, 512);
        for (int k = 0; k < DIR_ROWS; k++) send_req(dir_rows[k]);
        drain();

        // small period with more frames than ticks: zero-length frames
        write_reg(CFG_TOTAL_TICKS, 7);
        write_reg(CFG_FRAMES_IN_USE, 16);
        send_req(make_row(OP_ADD, 0, 7, 1000, -1000, 0));
        for (int k = 0; k < 16; k++) send_req(make_row(OP_READ, 0, 0, 0, 0, k));
        drain();

        // every frame of the sum memory in use, maximal period
        write_reg(CFG_TOTAL_TICKS, 1048575);
        write_reg(CFG_FRAMES_IN_USE, 1024);
        send_req(make_row(OP_ADD, 1047000, 1048575, 32767, -32768, 0));
        send_req(make_row(OP_READ, 0, 0, 0, 0, 1023));
        drain();

        // zero registers make adds do nothing
        write_reg(CFG_TOTAL_TICKS, 0);
        send_req(make_row(OP_ADD, 0, 100, 9, 9, 0));
        drain();
        write_reg(CFG_TOTAL_TICKS, 1);
        write_reg(CFG_FRAMES_IN_USE, 0);
        send_req(make_row(OP_ADD, 0, 1, 9, 9, 0));
        drain();
        write_reg(CFG_FRAMES_IN_USE, 1);
        send_req(make_row(OP_ADD, 0, 1, -32768, 32767, 0));
        send_req(make_row(OP_READ, 0, 0, 0, 0, 0));
        drain();

        // random phases over several settings; one phase without idling
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_reg(CFG_TOTAL_TICKS, 69888); write_reg(CFG_FRAMES_IN_USE, 882); end
                1: begin write_reg(CFG_TOTAL_TICKS, 1000); write_reg(CFG_FRAMES_IN_USE, 64); end
                2: begin write_reg(CFG_TOTAL_TICKS, 37); write_reg(CFG_FRAMES_IN_USE, 50); end
                3: begin write_reg(CFG_TOTAL_TICKS, 1048575); write_reg(CFG_FRAMES_IN_USE, 1024); end
                default: begin write_reg(CFG_TOTAL_TICKS, 5003); write_reg(CFG_FRAMES_IN_USE, 17); end
            endcase
            quiet_mode = (ph == 1);
            n = RANDOM_REQS / 5;
            for (int k = 0; k < n; k++) begin
                send_req(random_row());
                // sender holds off until every response is back
                if (k == n / 2) begin
                    req_bus.valid <= 1'b0;
                    while (pending_rsps.size() != 0) @(posedge i_clk);
                end
            end
            quiet_mode = 1'b0;
            drain();
        end

        $display("covered %0d requests, %0d responses checked (%0d reads), five settings",
                 sent_reqs, checked, reads_seen);
        if (mismatches == 0 && pending_rsps.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d left outstanding", mismatches, pending_rsps.size());
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ----- area_weighted_level_accumulator.f -----
+incdir+design
design/awla_pkg.sv
design/awla_req_if.sv
design/awla_rsp_if.sv
design/awla_front.sv
design/awla_fifo.sv
design/awla_div.sv
design/awla_back.sv
design/area_weighted_level_accumulator.sv
dv/area_weighted_level_accumulator_tb.sv
